[rtl/core/logistic_log_likelihood_core_defines.svh]
// Assertion macros used by the core's queue.
`ifndef LOGISTIC_LOG_LIKELIHOOD_CORE_DEFINES_SVH
`define LOGISTIC_LOG_LIKELIHOOD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/core/llc_pkg.sv]
package llc_pkg;

    localparam int FEAT_W    = 16;
    localparam int NUM_COEF  = 4;
    localparam int COEF_IDX_W = 2;
    localparam int APB_DW    = 32;
    localparam int PROD_W    = 2 * FEAT_W;
    localparam int Z_W       = PROD_W + 2;
    localparam int ZO_W      = 20;
    localparam int P_W       = 16;
    localparam int TERM_W    = 21;
    localparam int SUM_W     = 48;
    localparam int QUEUE_AW  = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] Z_LIM   = 64'd524288;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    typedef logic signed [FEAT_W-1:0] t_coef;
    typedef t_coef [NUM_COEF-1:0] t_coef_set;

    typedef struct packed {
        logic [ZO_W-1:0] z_ofs;
        logic            label;
        logic            is_last;
    } t_queue_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

    // restoring divider, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln of a positive integer, Q16.16
    function automatic logic [63:0] ln_int(input logic [63:0] a);
        logic [5:0]  k;
        logic [63:0] m;
        logic [63:0] l2;
        k = '0;
        for (int j = 1; j < 41; j++) begin
            if ((a >> j) != 64'd0) begin
                k = 6'(j);
            end
        end
        m  = a << (30 - int'(k));
        l2 = 64'(k) << 20;
        for (int i = 1; i <= 20; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m  = m >> 1;
                l2 = l2 | (64'd1 << (20 - i));
            end
        end
        return (l2 * LN2_Q32 + (64'd1 << 35)) >> 36;
    endfunction

    function automatic logic signed [TERM_W-1:0] log_entry(input logic [63:0] idx,
                                                            input logic [63:0] depth);
        logic [63:0] diff;
        diff = ln_int((idx << 1) + 64'd1) - ln_int(depth << 1);
        return TERM_W'(diff);
    endfunction

    // 2^16 / (exp(u) + 1), u in Q16.16
    function automatic logic [63:0] sig_low(input logic [63:0] u);
        logic [63:0] big;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] den;
        big  = u << 16;
        n    = udiv64(big, LN2_Q32);
        r    = big - n * LN2_Q32;
        acc  = ONE_Q32;
        term = ONE_Q32;
        for (int i = 1; i <= 14; i++) begin
            term = udiv64((term * r) >> 32, 64'(i));
            acc  = acc + term;
        end
        if (n > 64'd20) begin
            n = 64'd20;
        end
        den = (acc << n) + ONE_Q32;
        return udiv64((64'd1 << 48) + (den >> 1), den);
    endfunction

    function automatic logic [P_W-1:0] sig_entry(input logic [63:0] idx,
                                                 input logic [63:0] depth);
        logic [63:0] off;
        logic [63:0] p;
        off = udiv64(((idx << 1) + 64'd1) << 19, depth);
        if (off < Z_LIM) begin
            p = sig_low(Z_LIM - off);
        end else begin
            p = 64'd65536 - sig_low(off - Z_LIM);
        end
        if (p < 64'd1) begin
            p = 64'd1;
        end
        if (p > 64'd65535) begin
            p = 64'd65535;
        end
        return P_W'(p);
    endfunction

endpackage

[rtl/core/llc_queue.sv]
`include "logistic_log_likelihood_core_defines.svh"

module llc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  llc_pkg::t_queue_item i_push_item,
    input  logic                 i_pop,
    output llc_pkg::t_queue_item o_pop_item,
    output llc_pkg::t_queue_flags o_flags
);

    llc_pkg::t_queue_item r_mem [llc_pkg::QUEUE_DEPTH];
    logic [llc_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [llc_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [llc_pkg::QUEUE_AW:0]   r_count;

    assign o_pop_item    = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == (llc_pkg::QUEUE_AW + 1)'(llc_pkg::QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `LLC_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_flags.full, "push into full queue")
    `LLC_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_flags.empty, "pop from empty queue")
    `LLC_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count lost a push")

endmodule

[rtl/core/llc_front.sv]
module llc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  llc_pkg::t_coef_set    i_coefs,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [llc_pkg::NUM_COEF*llc_pkg::FEAT_W-1:0] i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    input  llc_pkg::t_queue_flags i_queue_flags,
    output logic                  o_push,
    output llc_pkg::t_queue_item  o_push_item
);

    logic signed [llc_pkg::PROD_W-1:0] r_f1_prod [llc_pkg::NUM_COEF];
    logic r_f1_valid;
    logic r_f1_label;
    logic r_f1_last;
    logic r_f2_valid;
    llc_pkg::t_queue_item r_f2_item;

    logic adv;
    logic signed [llc_pkg::Z_W-1:0] z;
    llc_pkg::t_queue_item n_item;

    assign adv         = !r_f2_valid || !i_queue_flags.full;
    assign o_s_tready  = adv;
    assign o_push      = r_f2_valid && !i_queue_flags.full;
    assign o_push_item = r_f2_item;

    always_comb begin
        z = '0;
        for (int k = 0; k < llc_pkg::NUM_COEF; k++) begin
            z = z + llc_pkg::Z_W'(r_f1_prod[k]);
        end
    end

    // clamp to [-8, 8) and offset by 8
    always_comb begin
        n_item.label   = r_f1_label;
        n_item.is_last = r_f1_last;
        if (z[llc_pkg::Z_W-1] && !(&z[llc_pkg::Z_W-2:llc_pkg::ZO_W-1])) begin
            n_item.z_ofs = '0;
        end else if (!z[llc_pkg::Z_W-1] && (|z[llc_pkg::Z_W-2:llc_pkg::ZO_W-1])) begin
            n_item.z_ofs = '1;
        end else begin
            n_item.z_ofs = {~z[llc_pkg::ZO_W-1], z[llc_pkg::ZO_W-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < llc_pkg::NUM_COEF; k++) begin
                r_f1_prod[k] <= llc_pkg::PROD_W'($signed(i_coefs[k]))
                              * llc_pkg::PROD_W'($signed(i_s_tdata[k*llc_pkg::FEAT_W +: llc_pkg::FEAT_W]));
            end
            r_f1_label <= i_s_tuser;
            r_f1_last  <= i_s_tlast;
            r_f2_item  <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (adv) begin
            r_f1_valid <= i_s_tvalid;
            r_f2_valid <= r_f1_valid;
        end
    end

endmodule

[rtl/core/llc_back.sv]
module llc_back #(
    parameter int SIGMOID_TABLE_DEPTH = 1024,
    parameter int LOG_TABLE_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  llc_pkg::t_queue_flags i_queue_flags,
    input  llc_pkg::t_queue_item  i_pop_item,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [llc_pkg::SUM_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    localparam int SIG_AW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int LOG_AW = $clog2(LOG_TABLE_DEPTH);
    localparam int SIG_PW = llc_pkg::ZO_W + SIG_AW + 1;
    localparam int LOG_PW = llc_pkg::P_W + LOG_AW + 1;
    localparam int SUM_W  = llc_pkg::SUM_W;

    typedef logic [llc_pkg::P_W-1:0] t_sig_rom [SIGMOID_TABLE_DEPTH];
    typedef logic signed [llc_pkg::TERM_W-1:0] t_log_rom [LOG_TABLE_DEPTH];

    function automatic t_sig_rom build_sig_rom();
        t_sig_rom rom;
        for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
            rom[i] = llc_pkg::sig_entry(64'(i), 64'(SIGMOID_TABLE_DEPTH));
        end
        return rom;
    endfunction

    function automatic t_log_rom build_log_rom();
        t_log_rom rom;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            rom[i] = llc_pkg::log_entry(64'(i), 64'(LOG_TABLE_DEPTH));
        end
        return rom;
    endfunction

    localparam t_sig_rom SigRom = build_sig_rom();
    localparam t_log_rom LogRom = build_log_rom();

    logic r_b1_valid;
    logic [SIG_AW-1:0] r_b1_idx;
    logic r_b1_label;
    logic r_b1_last;
    logic r_b2_valid;
    logic [llc_pkg::P_W-1:0] r_b2_p;
    logic r_b2_label;
    logic r_b2_last;
    logic r_b3_valid;
    logic [LOG_AW-1:0] r_b3_lidx;
    logic r_b3_last;
    logic r_b4_valid;
    logic signed [llc_pkg::TERM_W-1:0] r_b4_term;
    logic r_b4_last;
    logic signed [SUM_W-1:0] r_sum;
    logic r_clip;
    logic r_out_valid;
    logic [SUM_W-1:0] r_out_ll;
    logic r_out_sat;

    logic adv;
    logic [SIG_PW-1:0] sig_prod;
    logic [llc_pkg::P_W-1:0] q;
    logic [LOG_PW-1:0] log_prod;
    logic signed [SUM_W:0] sum_ext;
    logic clip;
    logic [SUM_W-1:0] n_sum;
    logic n_clip;

    assign adv   = !r_out_valid || i_m_tready;
    assign o_pop = adv && !i_queue_flags.empty;

    assign sig_prod = SIG_PW'(i_pop_item.z_ofs) * SIG_PW'(SIGMOID_TABLE_DEPTH);
    // label 0 looks up log(1 - p)
    assign q = r_b2_label ? r_b2_p
                          : llc_pkg::P_W'({1'b1, {llc_pkg::P_W{1'b0}}} - {1'b0, r_b2_p});
    assign log_prod = LOG_PW'(q) * LOG_PW'(LOG_TABLE_DEPTH);

    // terms are never positive: only the negative limit can be crossed
    assign sum_ext = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_b4_term);
    assign clip    = sum_ext[SUM_W] & ~sum_ext[SUM_W-1];
    assign n_sum   = clip ? {1'b1, {(SUM_W-1){1'b0}}} : sum_ext[SUM_W-1:0];
    assign n_clip  = r_clip | clip;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_ll;
    assign o_m_tuser  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_idx   <= sig_prod[llc_pkg::ZO_W +: SIG_AW];
            r_b1_label <= i_pop_item.label;
            r_b1_last  <= i_pop_item.is_last;
            r_b2_p     <= SigRom[r_b1_idx];
            r_b2_label <= r_b1_label;
            r_b2_last  <= r_b1_last;
            r_b3_lidx  <= log_prod[llc_pkg::P_W +: LOG_AW];
            r_b3_last  <= r_b2_last;
            r_b4_term  <= LogRom[r_b3_lidx];
            r_b4_last  <= r_b3_last;
            if (r_b4_valid && r_b4_last) begin
                r_out_ll  <= n_sum;
                r_out_sat <= n_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_b1_valid <= o_pop;
                r_b2_valid <= r_b1_valid;
                r_b3_valid <= r_b2_valid;
                r_b4_valid <= r_b3_valid;
                if (r_b4_valid) begin
                    if (r_b4_last) begin
                        r_sum  <= '0;
                        r_clip <= 1'b0;
                    end else begin
                        r_sum  <= n_sum;
                        r_clip <= n_clip;
                    end
                end
            end
            if (adv && r_b4_valid && r_b4_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/logistic_log_likelihood_core.sv]
// Logistic-regression log-likelihood core.
// Input stream: one design-matrix row per item. tdata carries four signed
// Q8.8 features, tuser the label (1 = affected), tlast marks the last row.
// Output stream: one item per data set, sent on the last row. tdata is the
// total log-likelihood, signed Q32.16, tuser is set if the sum saturated.
// Coefficients coef_0..coef_3 sit on the APB port at 0x0, 0x4, 0x8, 0xC
// and are written while the core is idle; the user must keep to this, the core does not enforce it.
// Throughput: one row per cycle until output back-pressure fills the queue. A
// row's four products, its sigmoid lookup, its log lookup and the add each
// occupy one pipeline stage. An accepted row passes the first and second front
// stages, the queue write, 4 back stages and the output register before output tvalid.
// Reset clears the coefficients, the running sum and the saturation flag.
// When the receiver holds tready low with a result pending, the back end
// stops; the front keeps taking rows until its 4-entry queue fills, then
// drops s_axis tready.
module logistic_log_likelihood_core #(
    parameter int SIGMOID_TABLE_DEPTH = 1024,
    parameter int LOG_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [llc_pkg::COEF_IDX_W+1:0] paddr,
    input  logic [llc_pkg::APB_DW-1:0]     pwdata,
    output logic [llc_pkg::APB_DW-1:0]     prdata,
    output logic        pready,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // feature_a [15:0], feature_b [31:16], feature_c [47:32], feature_d [63:48]
    input  logic [llc_pkg::NUM_COEF*llc_pkg::FEAT_W-1:0] i_s_axis_tdata,
    // label
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // log_likelihood [47:0]
    output logic [llc_pkg::SUM_W-1:0] o_m_axis_tdata,
    // saturated
    output logic        o_m_axis_tuser
);

    llc_pkg::t_coef_set r_coefs;

    logic [llc_pkg::COEF_IDX_W-1:0] reg_sel;
    logic cfg_wr;
    logic push;
    logic pop;
    llc_pkg::t_queue_item push_item;
    llc_pkg::t_queue_item pop_item;
    llc_pkg::t_queue_flags queue_flags;

    assign reg_sel = paddr[llc_pkg::COEF_IDX_W+1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = {{(llc_pkg::APB_DW - llc_pkg::FEAT_W){1'b0}}, r_coefs[reg_sel]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (cfg_wr) begin
            r_coefs[reg_sel] <= pwdata[llc_pkg::FEAT_W-1:0];
        end
    end

    llc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coefs       (r_coefs),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_s_tlast     (i_s_axis_tlast),
        .i_queue_flags (queue_flags),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    llc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_pop_item  (pop_item),
        .o_flags     (queue_flags)
    );

    llc_back #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
        .LOG_TABLE_DEPTH     (LOG_TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_flags (queue_flags),
        .i_pop_item    (pop_item),
        .o_pop         (pop),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tuser     (o_m_axis_tuser)
    );

endmodule

[test/logistic_log_likelihood_core_tb.sv]
module logistic_log_likelihood_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIG_DEPTH = 1024;
    localparam int LOG_DEPTH = 1024;
    localparam int ADDR_W = llc_pkg::COEF_IDX_W + 2;
    localparam int REG_STRIDE = 4;
    localparam int DRAIN_PAD = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ROWS = 1000;
    localparam int NUM_PHASES = 10;
    localparam int PRESSURE_ROWS = 60;
    localparam int MAX_REPORTS = 10;
    localparam longint Z_HALF = 64'sd524288;
    localparam longint SUM_FLOOR = -(64'sd1 <<< 47);
    localparam longint unsigned LN2_Q = 64'd2977044472;

    typedef logic signed [llc_pkg::FEAT_W-1:0] t_feat;
    typedef t_feat [llc_pkg::NUM_COEF-1:0] t_row_feat;

    typedef struct {
        logic [llc_pkg::SUM_W-1:0] total;
        logic                      sat;
    } t_ll_result;

    typedef struct packed {
        logic               wr;
        llc_pkg::t_coef_set coefs;
        t_row_feat          feat;
        logic               label;
        logic               last;
        logic               sat;
    } t_dir_row;

    // coefs and features: entry 0 in the lowest 16 bits
    localparam int NUM_DIR = 20;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h7FFF_8000_FFFF_0001, 1'b1, 1'b1, 1'b0},
        '{1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h8000_8000_8000_8000, 1'b1, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h8000_8000_8000_8000, 1'b0, 1'b1, 1'b0},
        '{1'b1, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b1, 1'b1, 1'b0},
        '{1'b0, 64'h0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 1'b1, 1'b0},
        '{1'b1, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_0800, 1'b1, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_F800, 1'b1, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_07FF, 1'b0, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_F801, 1'b0, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0100, 1'b1, 1'b0, 1'b0},
        // new coefficients while a data set is open
        '{1'b1, 64'h0080_FF00_0100_0000, 64'h0100_0100_0100_0100, 1'b0, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'h0200_0180_0040_1234, 1'b1, 1'b0, 1'b0},
        '{1'b0, 64'h0, 64'hFE00_0000_0300_0000, 1'b0, 1'b1, 1'b0},
        '{1'b1, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0},
        '{1'b0, 64'h0, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b1, 1'b0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [llc_pkg::APB_DW-1:0] pwdata = '0;
    logic [llc_pkg::APB_DW-1:0] prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [llc_pkg::NUM_COEF*llc_pkg::FEAT_W-1:0] s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [llc_pkg::SUM_W-1:0] m_tdata;
    logic                   m_tuser;

    int unsigned sig_p [SIG_DEPTH];
    longint      log_term [LOG_DEPTH];

    llc_pkg::t_coef_set coef_shadow = '0;
    longint      ll_sum = 0;
    bit          ll_clip = 1'b0;
    t_ll_result  ll_expected [$];
    t_ll_result  ll_head;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_pending = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int rows_sent = 0;
    int sets_seen = 0;
    int coef_loads = 0;

    logistic_log_likelihood_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[logistic_log_likelihood_core] ERROR");
        $finish;
    end

    // ln(a) in Q16.16 via repeated squaring of the mantissa
    function automatic longint nat_log_q16(longint unsigned a);
        int k;
        longint unsigned m;
        longint unsigned l2;
        k = 0;
        while (k < 40 && (a >> (k + 1)) != 0)
            k++;
        m = a << (30 - k);
        l2 = 64'(k) << 20;
        for (int i = 1; i <= 20; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                l2 |= 64'd1 << (20 - i);
            end
        end
        return longint'((l2 * LN2_Q + (64'd1 << 35)) >> 36);
    endfunction

    // round(2^16 / (exp(u) + 1)), u >= 0 in Q16.16
    function automatic longint unsigned exp_low_q16(longint unsigned u);
        longint unsigned big;
        longint unsigned n;
        longint unsigned r;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned den;
        big = u << 16;
        n = big / LN2_Q;
        r = big - n * LN2_Q;
        acc = 64'd1 << 32;
        term = acc;
        for (int i = 1; i <= 14; i++) begin
            term = ((term * r) >> 32) / 64'(i);
            acc += term;
        end
        if (n > 20)
            n = 20;
        den = (acc << n) + (64'd1 << 32);
        return ((64'd1 << 48) + (den >> 1)) / den;
    endfunction

    function automatic void build_tables();
        longint unsigned off;
        longint unsigned p;
        for (int idx = 0; idx < SIG_DEPTH; idx++) begin
            off = ((64'd2 * 64'(idx) + 64'd1) << 19) / 64'(SIG_DEPTH);
            if (off < 64'(Z_HALF))
                p = exp_low_q16(64'(Z_HALF) - off);
            else
                p = 64'd65536 - exp_low_q16(off - 64'(Z_HALF));
            if (p < 1)
                p = 1;
            if (p > 65535)
                p = 65535;
            sig_p[idx] = 32'(p);
        end
        for (int idx = 0; idx < LOG_DEPTH; idx++)
            log_term[idx] = nat_log_q16(64'd2 * 64'(idx) + 64'd1)
                          - nat_log_q16(64'd2 * 64'(LOG_DEPTH));
    endfunction

    // one row into the running log-likelihood; returns 1 when a total is due
    function automatic bit ll_model_row(t_row_feat f, bit label, bit last,
                                        output t_ll_result res);
        longint z;
        longint term;
        longint unsigned zi;
        longint unsigned q;
        z = 0;
        for (int i = 0; i < llc_pkg::NUM_COEF; i++)
            z += longint'(coef_shadow[i]) * longint'(f[i]);
        if (z < -Z_HALF)
            z = -Z_HALF;
        if (z > Z_HALF - 1)
            z = Z_HALF - 1;
        zi = 64'(((z + Z_HALF) * SIG_DEPTH) >>> 20);
        q = label ? 64'(sig_p[zi]) : 64'd65536 - 64'(sig_p[zi]);
        term = log_term[(q * LOG_DEPTH) >> 16];
        if (ll_sum + term < SUM_FLOOR) begin
            ll_sum = SUM_FLOOR;
            ll_clip = 1'b1;
        end else begin
            ll_sum += term;
        end
        res.total = llc_pkg::SUM_W'(ll_sum);
        res.sat = ll_clip;
        if (!last)
            return 1'b0;
        ll_sum = 0;
        ll_clip = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_feat rnd_feat();
        case ($urandom_range(0, 7))
            0: return t_feat'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return t_feat'($urandom_range(0, 2047)) - 16'sd1024;
        endcase
    endfunction

    function automatic llc_pkg::t_coef_set phase_coefs(int ph);
        llc_pkg::t_coef_set c;
        for (int i = 0; i < llc_pkg::NUM_COEF; i++) begin
            case (ph)
                0: c[i] = 16'sh7FFF;
                1: c[i] = 16'sh8000;
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        c[i] = llc_pkg::t_coef'($urandom);
                    else
                        c[i] = llc_pkg::t_coef'($urandom_range(0, 1023)) - 16'sd512;
                end
            endcase
        end
        if (ph == 2)
            c[llc_pkg::NUM_COEF-1] = '0;
        return c;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
    endtask

    task automatic send_row(t_row_feat f, bit label, bit last, bit sat_typed, bit sat_val);
        t_ll_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= f;
        s_tuser <= label;
        s_tlast <= last;
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        rows_sent++;
        if (ll_model_row(f, label, last, res)) begin
            if (sat_typed)
                res.sat = sat_val;
            ll_expected.push_back(res);
        end
    endtask

    task automatic wait_idle();
        while (ll_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic load_coefs(llc_pkg::t_coef_set c);
        for (int r = 0; r < llc_pkg::NUM_COEF; r++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_W'(r * REG_STRIDE);
            pwdata <= llc_pkg::APB_DW'(c[r]);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(negedge i_clk); while (!pready);
            @(posedge i_clk);
            coef_shadow[r] = c[r];
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        coef_loads++;
    endtask

    task automatic send_data_set(int len);
        t_row_feat f;
        for (int r = 0; r < len; r++) begin
            for (int i = 0; i < llc_pkg::NUM_COEF; i++)
                f[i] = rnd_feat();
            send_row(f, 1'($urandom_range(0, 1)), r == len - 1, 1'b0, 1'b0);
        end
    endtask

    // output side: ready pattern, with a long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_left = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sets_seen++;
            if (ll_expected.size() == 0) begin
                flag_mismatch("unexpected total", 0, m_tdata);
            end else begin
                ll_head = ll_expected.pop_front();
                if (m_tdata !== ll_head.total)
                    flag_mismatch("log_likelihood", ll_head.total, m_tdata);
                if (m_tuser !== ll_head.sat)
                    flag_mismatch("saturated", ll_head.sat, m_tuser);
            end
        end
    end

    initial begin
        int target;
        int drain;
        build_tables();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].wr) begin
                s_tvalid <= 1'b0;
                wait_idle();
                load_coefs(DIR_ROWS[i].coefs);
            end
            send_row(DIR_ROWS[i].feat, DIR_ROWS[i].label, DIR_ROWS[i].last,
                     1'b1, DIR_ROWS[i].sat);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            s_tvalid <= 1'b0;
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            load_coefs(phase_coefs(ph));
            target = rows_sent + RANDOM_ROWS / NUM_PHASES;
            while (rows_sent < target)
                send_data_set(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 10));
        end

        // single-row data sets against a stalled output: queue fills, input stalls
        s_tvalid <= 1'b0;
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_coefs(phase_coefs(NUM_PHASES));
        hold_pending = 1'b1;
        for (int n = 0; n < PRESSURE_ROWS; n++)
            send_data_set(1);

        s_tvalid <= 1'b0;
        drain = 0;
        while (ll_expected.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
        while (ll_expected.size() != 0) begin
            ll_head = ll_expected.pop_front();
            flag_mismatch("missing total", ll_head.total, 0);
        end

        $display("ran %0d rows, %0d totals checked, %0d coefficient sets, %0d mismatches",
                 rows_sent, sets_seen, coef_loads, mismatches);
        $display("idle/stall mixes plus a %0d-cycle output hold with back-to-back rows",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("[logistic_log_likelihood_core] OK");
        else
            $display("[logistic_log_likelihood_core] ERROR");
        $finish;
    end

endmodule
